// ===== sv/vumb_pkg.sv =====
// Package with shared types, constants and the log fraction function of the VU meter.
`timescale 1ns / 1ps

package vumb_pkg;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA    = 2'd0,
    CFG_CHANNELS = 2'd1,
    CFG_OFFSET   = 2'd2
  } vumb_cfg_e;

  localparam logic [23:0] ALPHA_RESET    = 24'd16776051;
  localparam logic [1:0]  CHANNELS_RESET = 2'd2;
  localparam logic [1:0]  CHANNELS_STEREO = 2'd2;
  localparam logic [9:0]  OFFSET_RESET   = 10'd288;

  localparam int VU_W = 10;
  localparam int PEG_W = 2;
  localparam int LOG_FRAC_W = 16;
  localparam int DB_SHIFT = 28;
  localparam int DB_OCT_W = 21;
  localparam logic signed [DB_OCT_W-1:0] DB_PER_OCTAVE_Q16 = 21'sd394566;

  localparam int VU_MIN = -320;
  localparam int VU_MAX = 48;

  localparam logic [PEG_W-1:0] PEG_NONE = 2'd0;
  localparam logic [PEG_W-1:0] PEG_LOW  = 2'd1;
  localparam logic [PEG_W-1:0] PEG_HIGH = 2'd2;

  typedef struct packed {
    logic pend;
    logic zero;
  } vumb_tag_t;

  // Base-2 log of (1 + step) in Q16, with step in Q30, found by repeated squaring.
  function automatic logic [LOG_FRAC_W-1:0] log2_frac_q16(input logic [63:0] step_q30);
    logic [63:0] xv;
    logic [LOG_FRAC_W-1:0] r;
    xv = (64'd1 << 30) + step_q30;
    r = '0;
    for (int k = 0; k < LOG_FRAC_W; k++) begin
      xv = (xv * xv) >> 30;
      r = {r[LOG_FRAC_W-2:0], 1'b0};
      if (xv >= (64'd1 << 31)) begin
        r[0] = 1'b1;
        xv = xv >> 1;
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/vumb_in_if.sv =====
// Channel that carries audio frames into the meter.
`timescale 1ns / 1ps

interface vumb_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;
  logic                          block_end;

  modport source (output valid, left_sample, right_sample, block_end, input ready);
  modport sink (input valid, left_sample, right_sample, block_end, output ready);
endinterface

// ===== sv/vumb_out_if.sv =====
// Channel that carries meter readings out of the meter.
`timescale 1ns / 1ps

interface vumb_out_if;
  logic              valid;
  logic              ready;
  logic signed [9:0] vu_level;
  logic [1:0]        pegged;

  modport source (output valid, vu_level, pegged, input ready);
  modport sink (input valid, vu_level, pegged, output ready);
endinterface

// ===== sv/vumb_integrator.sv =====
// Rectifier, channel average and one-pole level integrator.
`timescale 1ns / 1ps

module vumb_integrator #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_FRAC_BITS = 24
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     adv_i,
  input  logic                                     accept_i,
  input  logic signed [SAMPLE_BITS-1:0]            left_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]            right_sample_i,
  input  logic                                     block_end_i,
  input  logic [COEF_FRAC_BITS-1:0]                alpha_i,
  input  logic [1:0]                               channel_count_i,
  output logic [SAMPLE_BITS+COEF_FRAC_BITS-1:0]    level_o,
  output logic                                     pend_o
);
  import vumb_pkg::*;

  localparam int SW = SAMPLE_BITS;
  localparam int FW = COEF_FRAC_BITS;
  localparam int YW = SW + FW;

  logic [SW-1:0]   mag_l;
  logic [SW-1:0]   mag_r;
  logic [SW:0]     mag_sum;
  logic [SW-1:0]   avg;
  logic [SW-1:0]   hi;
  logic [FW-1:0]   lo;
  logic [FW:0]     one_minus_a;
  logic [FW+SW-1:0] t_hi;
  logic [FW+SW:0]  t_in;
  logic [2*FW-1:0] t_lo;
  logic [YW-1:0]   level_d;
  logic [YW-1:0]   level_q;
  logic            pend_d;
  logic            pend_q;

  always_comb begin
    mag_l = left_sample_i[SW-1] ? (~left_sample_i + SW'(1)) : left_sample_i;
    mag_r = right_sample_i[SW-1] ? (~right_sample_i + SW'(1)) : right_sample_i;
    mag_sum = (SW+1)'(mag_l) + (SW+1)'(mag_r);
    avg = (channel_count_i == CHANNELS_STEREO) ? mag_sum[SW:1] : mag_l;

    hi = level_q[YW-1:FW];
    lo = level_q[FW-1:0];
    one_minus_a = {1'b1, FW'(0)} - {1'b0, alpha_i};
    t_hi = (FW+SW)'(alpha_i) * (FW+SW)'(hi);
    t_in = (FW+SW+1)'(one_minus_a) * (FW+SW+1)'(avg);
    t_lo = (2*FW)'(alpha_i) * (2*FW)'(lo);
    level_d = YW'(t_hi) + YW'(t_in) + YW'(t_lo[2*FW-1:FW]);
    pend_d = accept_i & block_end_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      pend_q <= 1'b0;
    end else begin
      if (accept_i) begin
        level_q <= level_d;
      end
      if (adv_i) begin
        pend_q <= pend_d;
      end
    end
  end

  assign level_o = level_q;
  assign pend_o = pend_q;

endmodule

// ===== sv/vumb_log2.sv =====
// Leading-one detection and fraction table lookup that give the integrator's log2 in Q16.
`timescale 1ns / 1ps

module vumb_log2 #(
  parameter int YW                = 48,
  parameter int LOG_TABLE_ENTRIES = 32,
  parameter int LGW               = 23
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   pend_i,
  input  logic [YW-1:0]          level_i,
  output vumb_pkg::vumb_tag_t    tag_o,
  output logic signed [LGW-1:0]  lg_o
);
  import vumb_pkg::*;

  localparam int PW = $clog2(YW);
  localparam int IDXW = $clog2(LOG_TABLE_ENTRIES);
  localparam int NW = $clog2(LOG_TABLE_ENTRIES + 1);

  logic [LOG_FRAC_W-1:0] log_tab [LOG_TABLE_ENTRIES];

  for (genvar gi = 0; gi < LOG_TABLE_ENTRIES; gi++) begin : g_tab
    localparam logic [63:0] StepQ30 = (64'(gi) << 30) / LOG_TABLE_ENTRIES;
    assign log_tab[gi] = log2_frac_q16(StepQ30);
  end

  // First stage: leading-one position.
  vumb_tag_t       tag_a_d;
  vumb_tag_t       tag_a_q;
  logic [PW-1:0]   pos_d;
  logic [PW-1:0]   pos_q;
  logic [YW-1:0]   level_a_q;

  always_comb begin
    pos_d = '0;
    for (int i = 0; i < YW; i++) begin
      if (level_i[i]) begin
        pos_d = PW'(i);
      end
    end
    tag_a_d.pend = pend_i;
    tag_a_d.zero = (level_i == '0);
  end

  // Second stage: normalize, index the table and assemble the log.
  logic [PW-1:0]       shamt;
  logic [YW-1:0]       norm;
  logic [YW+29:0]      frac_wide;
  logic [30:0]         frac31;
  logic [30+NW:0]      idx_prod;
  logic [IDXW-1:0]     idx;
  logic signed [LGW-1:0] ipart;
  logic signed [LGW-1:0] lg_d;
  logic signed [LGW-1:0] lg_q;
  vumb_tag_t           tag_b_q;

  always_comb begin
    shamt = PW'(YW - 1) - pos_q;
    norm = level_a_q << shamt;
    frac_wide = {norm[YW-2:0], 31'b0};
    frac31 = frac_wide[YW+29 -: 31];
    idx_prod = (31+NW)'(frac31) * (31+NW)'(LOG_TABLE_ENTRIES);
    idx = idx_prod[31 +: IDXW];
    ipart = LGW'($signed({1'b0, pos_q})) - LGW'(YW - 1);
    lg_d = (ipart <<< LOG_FRAC_W) + LGW'(log_tab[idx]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
    end else if (adv_i) begin
      tag_a_q <= tag_a_d;
      tag_b_q <= tag_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pos_q <= pos_d;
      level_a_q <= level_i;
      lg_q <= lg_d;
    end
  end

  assign tag_o = tag_b_q;
  assign lg_o = lg_q;

endmodule

// ===== sv/vumb_scale.sv =====
// Decibel scaling, reference offset, clamping and the result register.
`timescale 1ns / 1ps

module vumb_scale #(
  parameter int LGW = 23
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  vumb_pkg::vumb_tag_t               tag_i,
  input  logic signed [LGW-1:0]             lg_i,
  input  logic [9:0]                        offset_i,
  output logic                              valid_o,
  output logic signed [vumb_pkg::VU_W-1:0]  vu_level_o,
  output logic [vumb_pkg::PEG_W-1:0]        pegged_o
);
  import vumb_pkg::*;

  localparam int PRW = LGW + DB_OCT_W;
  localparam int DBW = PRW - DB_SHIFT;
  localparam int VW = DBW + 2;

  logic signed [PRW-1:0] prod_d;
  logic signed [PRW-1:0] prod_q;
  vumb_tag_t             tag_c_q;
  logic signed [DBW-1:0] db16;
  logic signed [VW-1:0]  vu_sum;
  logic signed [VW-1:0]  offset_s;
  logic signed [VU_W-1:0] vu_d;
  logic [PEG_W-1:0]      peg_d;
  logic signed [VU_W-1:0] vu_q;
  logic [PEG_W-1:0]      peg_q;
  logic                  valid_q;

  always_comb begin
    prod_d = PRW'(lg_i) * PRW'(DB_PER_OCTAVE_Q16);
  end

  // The arithmetic shift floors toward minus infinity.
  always_comb begin
    db16 = prod_q[PRW-1:DB_SHIFT];
    offset_s = $signed(VW'(offset_i));
    vu_sum = VW'(db16) + offset_s;
    priority if (tag_c_q.zero) begin
      vu_d = VU_W'(VU_MIN);
      peg_d = PEG_LOW;
    end else if (vu_sum < VW'(VU_MIN)) begin
      vu_d = VU_W'(VU_MIN);
      peg_d = PEG_LOW;
    end else if (vu_sum > VW'(VU_MAX)) begin
      vu_d = VU_W'(VU_MAX);
      peg_d = PEG_HIGH;
    end else begin
      vu_d = VU_W'(vu_sum);
      peg_d = PEG_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_c_q <= '0;
      valid_q <= 1'b0;
    end else if (adv_i) begin
      tag_c_q <= tag_i;
      valid_q <= tag_c_q.pend;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= prod_d;
      vu_q <= vu_d;
      peg_q <= peg_d;
    end
  end

  assign valid_o = valid_q;
  assign vu_level_o = vu_q;
  assign pegged_o = peg_q;

endmodule

// ===== sv/vu_meter_ballistics.sv =====
// Top level of the VU meter: configuration registers, pipeline control and channels.
// A block-end frame yields a reading via the integrator, log2 and scale registers.
// One frame per cycle unless stalled; frames without block end give no reading.
// The whole pipeline stalls only while a reading waits and the output is not ready.
// The integrator updates in the cycle of acceptance, so level tracking has no gaps.
// Reset clears the integrator and pipeline tags and loads the default configuration.
`timescale 1ns / 1ps

module vu_meter_ballistics #(
  parameter int SAMPLE_BITS       = 24,
  parameter int COEF_FRAC_BITS    = 24,
  parameter int LOG_TABLE_ENTRIES = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [vumb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COEF_FRAC_BITS-1:0]      cfg_data_i,
  vumb_in_if.sink                        frame_i,
  vumb_out_if.source                     reading_o
);
  import vumb_pkg::*;

  localparam int YW = SAMPLE_BITS + COEF_FRAC_BITS;
  localparam int LGW = $clog2(YW) + LOG_FRAC_W + 1;

  logic [COEF_FRAC_BITS-1:0] alpha_q;
  logic [1:0]                chan_q;
  logic [9:0]                offset_q;

  logic                  adv;
  logic                  accept;
  logic [YW-1:0]         level;
  logic                  pend;
  vumb_tag_t             tag;
  logic signed [LGW-1:0] lg;
  logic                  out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= COEF_FRAC_BITS'(ALPHA_RESET);
      chan_q <= CHANNELS_RESET;
      offset_q <= OFFSET_RESET;
    end else if (cfg_we_i) begin
      unique case (vumb_cfg_e'(cfg_index_i))
        CFG_ALPHA: alpha_q <= cfg_data_i;
        CFG_CHANNELS: chan_q <= cfg_data_i[1:0];
        CFG_OFFSET: offset_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  assign adv = !out_valid || reading_o.ready;
  assign accept = frame_i.valid && adv;
  assign frame_i.ready = adv;

  vumb_integrator #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_integrator (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .accept_i        (accept),
    .left_sample_i   (frame_i.left_sample),
    .right_sample_i  (frame_i.right_sample),
    .block_end_i     (frame_i.block_end),
    .alpha_i         (alpha_q),
    .channel_count_i (chan_q),
    .level_o         (level),
    .pend_o          (pend)
  );

  vumb_log2 #(
    .YW                (YW),
    .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES),
    .LGW               (LGW)
  ) u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .pend_i  (pend),
    .level_i (level),
    .tag_o   (tag),
    .lg_o    (lg)
  );

  vumb_scale #(
    .LGW (LGW)
  ) u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .tag_i      (tag),
    .lg_i       (lg),
    .offset_i   (offset_q),
    .valid_o    (out_valid),
    .vu_level_o (reading_o.vu_level),
    .pegged_o   (reading_o.pegged)
  );

  assign reading_o.valid = out_valid;

endmodule

// ===== sv/vumb_checker.sv =====
// Port-level checker for the VU meter and its bind to the top level.
`timescale 1ns / 1ps

module vumb_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic signed [9:0] vu_level_i,
  input logic [1:0]        pegged_i
);
  import vumb_pkg::*;

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (vu_level_i >= 10'(VU_MIN)) && (vu_level_i <= 10'(VU_MAX)))
    else $error("reading outside the clamp range");

  a_peg_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (pegged_i == PEG_LOW) |-> vu_level_i == 10'(VU_MIN))
    else $error("bottom clamp flag without bottom reading");

  a_peg_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pegged_i != PEG_HIGH || vu_level_i == 10'(VU_MAX)) &&
                    (pegged_i == PEG_NONE || pegged_i == PEG_LOW || pegged_i == PEG_HIGH))
    else $error("bad top clamp flag");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(vu_level_i) && $stable(pegged_i))
    else $error("stalled reading changed");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("frame taken while a reading is stalled");

endmodule

bind vu_meter_ballistics vumb_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (frame_i.ready),
  .out_valid_i (reading_o.valid),
  .out_ready_i (reading_o.ready),
  .vu_level_i  (reading_o.vu_level),
  .pegged_i    (reading_o.pegged)
);
